// ===== sv/tta_pkg.sv =====
// Shared types, constants and a clamp helper function for the three-way thrust allocator.
// Depends on nothing; every other file refers to it by scoped names.

package tta_pkg;

  // Field and internal widths.
  localparam int unsigned DataW = 32;             // Q16.16 signed ports
  localparam int unsigned CmdW  = 34;             // sum of three 32-bit values
  localparam int unsigned AbsW  = CmdW - 1;       // magnitude of a clamped demand
  localparam int unsigned CntW  = 2;              // adjustable thruster count, 0..3
  localparam int unsigned RemW  = 36;             // remainder and clamp width
  localparam int unsigned CfgIdxW = 3;

  // Division by three as a multiply by ceil(2^35 / 3) and a right shift by 35.
  // This is exact for every magnitude below 2^35.
  localparam int unsigned RecipW     = 34;
  localparam int unsigned RecipShift = 35;
  localparam logic [RecipW-1:0] RecipThree = 34'h2_AAAA_AAAB;

  // Partial products: the magnitude is split into a high and a low half.
  localparam int unsigned LoW    = 16;
  localparam int unsigned HiW    = AbsW - LoW;
  localparam int unsigned PHiW   = HiW + RecipW;
  localparam int unsigned PLoW   = LoW + RecipW;
  localparam int unsigned ProdW  = PHiW + LoW;
  localparam int unsigned QuotW  = ProdW - RecipShift;

  // Adjustable thruster counts.
  localparam logic [CntW-1:0] CntNone  = 2'd0;
  localparam logic [CntW-1:0] CntOne   = 2'd1;
  localparam logic [CntW-1:0] CntTwo   = 2'd2;
  localparam logic [CntW-1:0] CntThree = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FRONT_MIN = 3'd0,
    REG_FRONT_MAX = 3'd1,
    REG_LEFT_MIN  = 3'd2,
    REG_LEFT_MAX  = 3'd3,
    REG_RIGHT_MIN = 3'd4,
    REG_RIGHT_MAX = 3'd5
  } reg_idx_e;

  // Thruster limits as seen by the datapath.
  typedef struct packed {
    logic signed [DataW-1:0] front_min;
    logic signed [DataW-1:0] front_max;
    logic signed [DataW-1:0] left_min;
    logic signed [DataW-1:0] left_max;
    logic signed [DataW-1:0] right_min;
    logic signed [DataW-1:0] right_max;
  } cfg_t;

  // Clamp x to lo, then to hi, in that order, so inverted limits give lo or hi.
  function automatic logic signed [RemW-1:0] clamp_s(
    input logic signed [RemW-1:0] x,
    input logic signed [RemW-1:0] lo,
    input logic signed [RemW-1:0] hi
  );
    logic signed [RemW-1:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

// ===== sv/tta_cfg.sv =====
// Configuration register file holding the six thruster limits.
// Depends on tta_pkg for the register index enum and the limit struct.

module tta_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [tta_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [tta_pkg::DataW-1:0]           cfg_data_i,
  output tta_pkg::cfg_t                       cfg_o
);

  tta_pkg::cfg_t cfg_q;

  // Writes to an index past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (tta_pkg::reg_idx_e'(cfg_index_i))
        tta_pkg::REG_FRONT_MIN: cfg_q.front_min <= cfg_data_i;
        tta_pkg::REG_FRONT_MAX: cfg_q.front_max <= cfg_data_i;
        tta_pkg::REG_LEFT_MIN:  cfg_q.left_min  <= cfg_data_i;
        tta_pkg::REG_LEFT_MAX:  cfg_q.left_max  <= cfg_data_i;
        tta_pkg::REG_RIGHT_MIN: cfg_q.right_min <= cfg_data_i;
        tta_pkg::REG_RIGHT_MAX: cfg_q.right_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/tta_split.sv =====
// Front half of the pipeline: demand clamp, magnitude, reciprocal multiply, equal share.
// Four register stages with valid bits; depends on tta_pkg.

module tta_split (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tta_pkg::cfg_t                         cfg_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [tta_pkg::DataW-1:0]      demand_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [tta_pkg::CmdW-1:0]       share_o,
  output logic signed [tta_pkg::CmdW-1:0]       cmd_o,
  output logic                                  none_o
);

  localparam int unsigned CmdW  = tta_pkg::CmdW;
  localparam int unsigned AbsW  = tta_pkg::AbsW;
  localparam int unsigned CntW  = tta_pkg::CntW;
  localparam int unsigned LoW   = tta_pkg::LoW;
  localparam int unsigned PHiW  = tta_pkg::PHiW;
  localparam int unsigned PLoW  = tta_pkg::PLoW;
  localparam int unsigned ProdW = tta_pkg::ProdW;
  localparam int unsigned QuotW = tta_pkg::QuotW;
  localparam int unsigned NumSt = 4;

  logic [NumSt-1:0] v_q;
  logic [NumSt-1:0] adv;

  // Each stage moves when it is empty or the next one moves.
  always_comb begin
    adv[NumSt-1] = !v_q[NumSt-1] || ready_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumSt; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NumSt-1];

  // Stage 1: clamp the demand to the summed limits and count adjustable thrusters.
  logic signed [CmdW-1:0] sum_min;
  logic signed [CmdW-1:0] sum_max;
  logic signed [CmdW-1:0] dem_ext;
  logic signed [CmdW-1:0] s1_cmd_d, s1_cmd_q;
  logic [CntW-1:0]        s1_cnt_d, s1_cnt_q;

  always_comb begin
    sum_min = CmdW'(cfg_i.front_min) + CmdW'(cfg_i.left_min) + CmdW'(cfg_i.right_min);
    sum_max = CmdW'(cfg_i.front_max) + CmdW'(cfg_i.left_max) + CmdW'(cfg_i.right_max);
    dem_ext = CmdW'(demand_i);
    if (dem_ext < sum_min) begin
      s1_cmd_d = sum_min;
    end else if (dem_ext > sum_max) begin
      s1_cmd_d = sum_max;
    end else begin
      s1_cmd_d = dem_ext;
    end
    s1_cnt_d = CntW'(cfg_i.front_max > cfg_i.front_min)
             + CntW'(cfg_i.left_max > cfg_i.left_min)
             + CntW'(cfg_i.right_max > cfg_i.right_min);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_cmd_q <= s1_cmd_d;
      s1_cnt_q <= s1_cnt_d;
    end
  end

  // Stage 2: take the magnitude so the division truncates toward zero.
  logic signed [CmdW-1:0] s1_neg_cmd;
  logic [AbsW-1:0]        s2_abs_q;
  logic                   s2_neg_q;
  logic [CntW-1:0]        s2_cnt_q;
  logic signed [CmdW-1:0] s2_cmd_q;

  assign s1_neg_cmd = -s1_cmd_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_abs_q <= s1_cmd_q[CmdW-1] ? s1_neg_cmd[AbsW-1:0] : s1_cmd_q[AbsW-1:0];
      s2_neg_q <= s1_cmd_q[CmdW-1];
      s2_cnt_q <= s1_cnt_q;
      s2_cmd_q <= s1_cmd_q;
    end
  end

  // Stage 3: two partial products of the magnitude with the reciprocal of three.
  logic [PHiW-1:0]        s3_phi_d, s3_phi_q;
  logic [PLoW-1:0]        s3_plo_d, s3_plo_q;
  logic [AbsW-1:0]        s3_abs_q;
  logic                   s3_neg_q;
  logic [CntW-1:0]        s3_cnt_q;
  logic signed [CmdW-1:0] s3_cmd_q;

  assign s3_phi_d = s2_abs_q[AbsW-1:LoW] * tta_pkg::RecipThree;
  assign s3_plo_d = s2_abs_q[LoW-1:0] * tta_pkg::RecipThree;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_phi_q <= s3_phi_d;
      s3_plo_q <= s3_plo_d;
      s3_abs_q <= s2_abs_q;
      s3_neg_q <= s2_neg_q;
      s3_cnt_q <= s2_cnt_q;
      s3_cmd_q <= s2_cmd_q;
    end
  end

  // Stage 4: combine the products, pick the quotient for the count, restore the sign.
  logic [ProdW-1:0]       prod;
  logic [AbsW-1:0]        quot;
  logic signed [CmdW-1:0] quot_s;
  logic signed [CmdW-1:0] s4_share_q;
  logic signed [CmdW-1:0] s4_cmd_q;
  logic                   s4_none_q;

  always_comb begin
    prod = {s3_phi_q, {LoW{1'b0}}} + ProdW'(s3_plo_q);
    case (s3_cnt_q)
      tta_pkg::CntTwo:   quot = s3_abs_q >> 1;
      tta_pkg::CntThree: quot = AbsW'(prod[ProdW-1 -: QuotW]);
      default:           quot = s3_abs_q;
    endcase
    quot_s = $signed({1'b0, quot});
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_share_q <= s3_neg_q ? -quot_s : quot_s;
      s4_cmd_q   <= s3_cmd_q;
      s4_none_q  <= (s3_cnt_q == tta_pkg::CntNone);
    end
  end

  assign share_o = s4_share_q;
  assign cmd_o   = s4_cmd_q;
  assign none_o  = s4_none_q;

endmodule

// ===== sv/tta_fill.sv =====
// Back half of the pipeline: per-thruster clamp, shortfall, and front-left-right top-up.
// Five register stages with valid bits; the last stage is the output register. Depends on tta_pkg.

module tta_fill (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tta_pkg::cfg_t                         cfg_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [tta_pkg::CmdW-1:0]       share_i,
  input  logic signed [tta_pkg::CmdW-1:0]       cmd_i,
  input  logic                                  none_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [tta_pkg::DataW-1:0]      front_o,
  output logic signed [tta_pkg::DataW-1:0]      left_o,
  output logic signed [tta_pkg::DataW-1:0]      right_o
);

  localparam int unsigned DataW = tta_pkg::DataW;
  localparam int unsigned CmdW  = tta_pkg::CmdW;
  localparam int unsigned RemW  = tta_pkg::RemW;
  localparam int unsigned NumSt = 5;

  logic [NumSt-1:0] v_q;
  logic [NumSt-1:0] adv;

  // Each stage moves when it is empty or the next one moves.
  always_comb begin
    adv[NumSt-1] = !v_q[NumSt-1] || ready_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumSt; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NumSt-1];

  // Stage 5: clamp the equal share to each thruster's limits.
  logic signed [RemW-1:0]  share_ext;
  logic signed [RemW-1:0]  cf_f, cf_l, cf_r;
  logic signed [DataW-1:0] s5_f_q, s5_l_q, s5_r_q;
  logic signed [CmdW-1:0]  s5_cmd_q;
  logic                    s5_none_q;

  always_comb begin
    share_ext = RemW'(share_i);
    cf_f = tta_pkg::clamp_s(share_ext, RemW'(cfg_i.front_min), RemW'(cfg_i.front_max));
    cf_l = tta_pkg::clamp_s(share_ext, RemW'(cfg_i.left_min), RemW'(cfg_i.left_max));
    cf_r = tta_pkg::clamp_s(share_ext, RemW'(cfg_i.right_min), RemW'(cfg_i.right_max));
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s5_f_q    <= cf_f[DataW-1:0];
      s5_l_q    <= cf_l[DataW-1:0];
      s5_r_q    <= cf_r[DataW-1:0];
      s5_cmd_q  <= cmd_i;
      s5_none_q <= none_i;
    end
  end

  // Stage 6: shortfall between the clamped demand and the three clamped shares.
  logic signed [RemW-1:0]  s6_rem_q;
  logic signed [DataW-1:0] s6_f_q, s6_l_q, s6_r_q;
  logic                    s6_none_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s6_rem_q  <= RemW'(s5_cmd_q) - RemW'(s5_f_q) - RemW'(s5_l_q) - RemW'(s5_r_q);
      s6_f_q    <= s5_f_q;
      s6_l_q    <= s5_l_q;
      s6_r_q    <= s5_r_q;
      s6_none_q <= s5_none_q;
    end
  end

  // Stage 7: top up the front thruster toward its maximum.
  logic signed [RemW-1:0]  add_f;
  logic signed [RemW-1:0]  s7_rem_q;
  logic signed [DataW-1:0] s7_f_q, s7_l_q, s7_r_q;
  logic                    s7_none_q;

  assign add_f = tta_pkg::clamp_s(s6_rem_q, '0, RemW'(cfg_i.front_max) - RemW'(s6_f_q));

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s7_rem_q  <= s6_rem_q - add_f;
      s7_f_q    <= s6_f_q + add_f[DataW-1:0];
      s7_l_q    <= s6_l_q;
      s7_r_q    <= s6_r_q;
      s7_none_q <= s6_none_q;
    end
  end

  // Stage 8: top up the left thruster with what is still missing.
  logic signed [RemW-1:0]  add_l;
  logic signed [RemW-1:0]  s8_rem_q;
  logic signed [DataW-1:0] s8_f_q, s8_l_q, s8_r_q;
  logic                    s8_none_q;

  assign add_l = tta_pkg::clamp_s(s7_rem_q, '0, RemW'(cfg_i.left_max) - RemW'(s7_l_q));

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s8_rem_q  <= s7_rem_q - add_l;
      s8_f_q    <= s7_f_q;
      s8_l_q    <= s7_l_q + add_l[DataW-1:0];
      s8_r_q    <= s7_r_q;
      s8_none_q <= s7_none_q;
    end
  end

  // Stage 9: top up the right thruster; with no adjustable thruster every output is its minimum.
  logic signed [RemW-1:0]  add_r;
  logic signed [DataW-1:0] s9_f_q, s9_l_q, s9_r_q;

  assign add_r = tta_pkg::clamp_s(s8_rem_q, '0, RemW'(cfg_i.right_max) - RemW'(s8_r_q));

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      if (s8_none_q) begin
        s9_f_q <= cfg_i.front_min;
        s9_l_q <= cfg_i.left_min;
        s9_r_q <= cfg_i.right_min;
      end else begin
        s9_f_q <= s8_f_q;
        s9_l_q <= s8_l_q;
        s9_r_q <= s8_r_q + add_r[DataW-1:0];
      end
    end
  end

  assign front_o = s9_f_q;
  assign left_o  = s9_l_q;
  assign right_o = s9_r_q;

endmodule

// ===== sv/three_way_thrust_allocator.sv =====
// Top level of the three-way thrust allocator: limit registers and a nine-stage pipeline.
// Depends on tta_pkg, tta_cfg, tta_split and tta_fill.
//
//   Channel   Handshake                    Word contents
//   -------   --------------------------   ---------------------------------------------
//   cfg       cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i (one limit register)
//   in        in_valid_i / in_ready_o      total_demand_i
//   out       out_valid_o / out_ready_i    front_thrust_o, left_thrust_o, right_thrust_o
//
// One input word is taken per cycle when nothing downstream stalls. Its result word is
// shown on the out channel after it has passed the nine register stages, in this order:
// demand clamp, magnitude, two partial products of the divide by three, quotient and
// sign, per-thruster clamp, shortfall, and one top-up stage per thruster.
// Reset clears the limit registers to zero and empties every stage.
// A stall holds each full stage from the output back to the first empty one; stages before that keep filling.

module three_way_thrust_allocator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tta_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [tta_pkg::DataW-1:0]             cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [tta_pkg::DataW-1:0]      total_demand_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tta_pkg::DataW-1:0]      front_thrust_o,
  output logic signed [tta_pkg::DataW-1:0]      left_thrust_o,
  output logic signed [tta_pkg::DataW-1:0]      right_thrust_o
);

  tta_pkg::cfg_t                      cfg;
  logic                               mid_valid;
  logic                               mid_ready;
  logic signed [tta_pkg::CmdW-1:0]    mid_share;
  logic signed [tta_pkg::CmdW-1:0]    mid_cmd;
  logic                               mid_none;

  // Limit registers accept a write every cycle.
  assign cfg_ready_o = 1'b1;

  tta_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Demand clamp and equal share.
  tta_split u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .demand_i (total_demand_i),
    .valid_o  (mid_valid),
    .ready_i  (mid_ready),
    .share_o  (mid_share),
    .cmd_o    (mid_cmd),
    .none_o   (mid_none)
  );

  // Per-thruster clamp and shortfall top-up.
  tta_fill u_fill (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .share_i (mid_share),
    .cmd_i   (mid_cmd),
    .none_i  (mid_none),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .front_o (front_thrust_o),
    .left_o  (left_thrust_o),
    .right_o (right_thrust_o)
  );

endmodule
